// File: src/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 transcoder: beat types, command and status
// structs, and code point constants. No dependencies.
package u8u16_pkg;

    localparam logic [15:0] REPL_CHAR = 16'hFFFD;
    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [20:0] CODE_MAX  = 21'h10FFFF;
    localparam logic [15:0] HI_BASE   = 16'hD800;
    localparam logic [15:0] LO_BASE   = 16'hDC00;
    localparam int          WIN_DEPTH = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } out_beat_t;

    typedef struct packed {
        logic append;
        logic emit_main;
        logic emit_low;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic pair;
        logic rest_empty;
        logic empty;
    } stat_t;

endpackage

// File: src/utf8_to_utf16_transcoder_unit.sv
// Top level of the UTF-8 to UTF-16 transcoder: controller plus datapath.
// Depends on u8u16_pkg, u8u16_ctrl and u8u16_datapath.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_ready | in_data   (in_byte, end_of_text)
//   out     | output    | out_valid/out_ready | out_data  (code_unit, last_unit)
//
// A byte that completes nothing is accepted, then the window is checked once.
// A byte that completes sequences is accepted, then each decoded sequence and
// each low surrogate takes its own step, plus a final check if a prefix remains.
// Reset clears the state machine, the byte count and the output valid flag.
// Each decode step waits while the single output register holds an untaken beat.
module utf8_to_utf16_transcoder_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  u8u16_pkg::in_beat_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output u8u16_pkg::out_beat_t out_data
);

    u8u16_pkg::cmd_t  cmd;
    u8u16_pkg::stat_t stat;

    u8u16_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    u8u16_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

// File: src/u8u16_datapath.sv
// Datapath: byte window, front sequence decoder, surrogate split and output
// payload register. Uses u8u16_pkg.
module u8u16_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  u8u16_pkg::in_beat_t in_data,
    input  u8u16_pkg::cmd_t     cmd,
    output u8u16_pkg::stat_t    stat,
    output u8u16_pkg::out_beat_t out_data
);

    logic [7:0]  win_reg [u8u16_pkg::WIN_DEPTH];
    logic [7:0]  win_next [u8u16_pkg::WIN_DEPTH];
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic        end_reg;
    logic [15:0] unit_reg;
    logic        last_reg;
    logic [15:0] lo_reg;
    logic        lo_last_reg;

    logic [7:0]  lead;
    logic [1:0]  extra;
    logic        bad_lead;
    logic        incomplete;
    logic [3:1]  cont_ok;
    logic [2:0]  used;
    logic [20:0] code;
    logic [20:0] offset;
    logic        pair;
    logic        over;
    logic [15:0] main_unit;
    logic [15:0] low_unit;
    logic [2:0]  rest;
    logic [2:0]  idx;

    assign lead = win_reg[0];

    always_comb
    begin
        bad_lead = 1'b0;
        if (lead[7] == 1'b0)
            extra = 2'd0;
        else if ((lead & 8'hE0) == 8'hC0)
            extra = 2'd1;
        else if ((lead & 8'hF0) == 8'hE0)
            extra = 2'd2;
        else if ((lead & 8'hF8) == 8'hF0)
            extra = 2'd3;
        else
        begin
            extra    = 2'd0;
            bad_lead = 1'b1;
        end
    end

    always_comb
    begin
        for (int i = 1; i < u8u16_pkg::WIN_DEPTH; i++)
        begin
            cont_ok[i] = (win_reg[i] & 8'hC0) == 8'h80;
        end
    end

    assign incomplete = count_reg < ({1'b0, extra} + 3'd1);

    always_comb
    begin
        code = {5'd0, u8u16_pkg::REPL_CHAR};
        used = 3'd1;
        if (!incomplete)
        begin
            case (extra)
                2'd0:
                begin
                    used = 3'd1;
                    if (!bad_lead)
                        code = {13'd0, lead};
                end
                2'd1:
                begin
                    if (!cont_ok[1])
                        used = 3'd1;
                    else
                    begin
                        used = 3'd2;
                        code = {10'd0, lead[4:0], win_reg[1][5:0]};
                    end
                end
                2'd2:
                begin
                    if (!cont_ok[1])
                        used = 3'd1;
                    else if (!cont_ok[2])
                        used = 3'd2;
                    else
                    begin
                        used = 3'd3;
                        code = {5'd0, lead[3:0], win_reg[1][5:0], win_reg[2][5:0]};
                    end
                end
                default:
                begin
                    if (!cont_ok[1])
                        used = 3'd1;
                    else if (!cont_ok[2])
                        used = 3'd2;
                    else if (!cont_ok[3])
                        used = 3'd3;
                    else
                    begin
                        used = 3'd4;
                        code = {lead[2:0], win_reg[1][5:0], win_reg[2][5:0],
                                win_reg[3][5:0]};
                    end
                end
            endcase
        end
    end

    assign pair      = (code >= u8u16_pkg::SUPP_BASE) && (code <= u8u16_pkg::CODE_MAX);
    assign over      = code > u8u16_pkg::CODE_MAX;
    assign offset    = code - u8u16_pkg::SUPP_BASE;
    assign low_unit  = u8u16_pkg::LO_BASE + {6'd0, offset[9:0]};
    assign main_unit = pair ? (u8u16_pkg::HI_BASE + {6'd0, offset[19:10]})
                     : over ? u8u16_pkg::REPL_CHAR : code[15:0];
    assign rest      = count_reg - used;

    assign stat.done       = (count_reg == 3'd0) || (incomplete && !end_reg);
    assign stat.pair       = pair;
    assign stat.rest_empty = rest == 3'd0;
    assign stat.empty      = count_reg == 3'd0;

    always_comb
    begin
        idx        = 3'd0;
        count_next = count_reg;
        for (int i = 0; i < u8u16_pkg::WIN_DEPTH; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (cmd.append && (count_reg < 3'(u8u16_pkg::WIN_DEPTH)))
        begin
            win_next[count_reg[1:0]] = in_data.in_byte;
            count_next               = count_reg + 3'd1;
        end
        else if (cmd.emit_main)
        begin
            for (int i = 0; i < u8u16_pkg::WIN_DEPTH; i++)
            begin
                idx = 3'(i) + used;
                if (idx < 3'(u8u16_pkg::WIN_DEPTH))
                    win_next[i] = win_reg[idx[1:0]];
            end
            count_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 3'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < u8u16_pkg::WIN_DEPTH; i++)
        begin
            win_reg[i] <= win_next[i];
        end
        if (cmd.append)
            end_reg <= in_data.end_of_text;
        if (cmd.emit_main)
        begin
            unit_reg    <= main_unit;
            last_reg    <= end_reg && !pair && (rest == 3'd0);
            lo_reg      <= low_unit;
            lo_last_reg <= end_reg && (rest == 3'd0);
        end
        else if (cmd.emit_low)
        begin
            unit_reg <= lo_reg;
            last_reg <= lo_last_reg;
        end
    end

    assign out_data.code_unit = unit_reg;
    assign out_data.last_unit = last_reg;

endmodule

// File: src/u8u16_ctrl.sv
// Controller: accepts a byte, steps the decoder once per sequence and holds
// the output beat valid flag. Uses u8u16_pkg.
module u8u16_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  u8u16_pkg::stat_t stat,
    output u8u16_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DECODE = 3'b010,
        S_LOW    = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.append = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.done)
                    state_next = S_IDLE;
                else if (out_free)
                begin
                    cmd.emit_main = 1'b1;
                    if (stat.pair)
                        state_next = S_LOW;
                    else if (stat.rest_empty)
                        state_next = S_IDLE;
                end
            end
            S_LOW:
            begin
                if (out_free)
                begin
                    cmd.emit_low = 1'b1;
                    state_next   = stat.empty ? S_IDLE : S_DECODE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.emit_main || cmd.emit_low)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_main || cmd.emit_low) |-> (!out_valid_reg || out_ready))
        else $error("beat loaded over a waiting beat");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_main || cmd.emit_low) |=> out_valid_reg)
        else $error("loaded beat not marked valid");

    a_low_after_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECODE && cmd.emit_main && stat.pair) |=> (state_reg == S_LOW))
        else $error("low surrogate step skipped");

    a_low_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOW && !$past(state_reg == S_LOW)) |-> $past(cmd.emit_main))
        else $error("low surrogate step without high surrogate");

endmodule

// File: bench/utf8_to_utf16_transcoder_unit_tb.sv
// Self-checking bench for utf8_to_utf16_transcoder_unit: byte texts in, predicted
// UTF-16 units compared beat by beat. Depends on u8u16_pkg and the top level only.
`timescale 1ns / 100ps

module utf8_to_utf16_transcoder_unit_tb;

    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;
    localparam int MAX_PER_BYTE = 4;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    u8u16_pkg::in_beat_t  in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    u8u16_pkg::out_beat_t out_data;

    u8u16_pkg::in_beat_t  pending_bytes[$];
    u8u16_pkg::out_beat_t expected_units[$];
    u8u16_pkg::out_beat_t step_units[$];
    logic [7:0]           win_q[4];
    int unsigned          win_len = 0;

    int send_idle_pct = 20;
    int recv_idle_pct = 50;
    bit hold_req      = 1'b0;
    int hold_left     = 0;
    int cycle_cnt     = 0;
    int mismatches    = 0;
    int units_checked = 0;
    int bytes_sent    = 0;
    int texts_built   = 0;

    utf8_to_utf16_transcoder_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic push_code(input int unsigned cp);
        int unsigned          v;
        u8u16_pkg::out_beat_t u;
        v = cp - u8u16_pkg::SUPP_BASE;
        u.last_unit = 1'b0;
        if (step_units.size() < MAX_PER_BYTE)
        begin
            if (cp >= u8u16_pkg::SUPP_BASE && cp <= u8u16_pkg::CODE_MAX)
            begin
                u.code_unit = u8u16_pkg::HI_BASE + 16'(v >> 10);
                step_units.push_back(u);
                if (step_units.size() < MAX_PER_BYTE)
                begin
                    u.code_unit = u8u16_pkg::LO_BASE + 16'(v & 32'h3FF);
                    step_units.push_back(u);
                end
            end
            else
            begin
                u.code_unit = (cp > u8u16_pkg::CODE_MAX) ? u8u16_pkg::REPL_CHAR : 16'(cp);
                step_units.push_back(u);
            end
        end
    endtask

    task automatic transcode_byte(input u8u16_pkg::in_beat_t b);
        logic [7:0]  lead;
        int unsigned extra;
        int unsigned used;
        int unsigned cp;
        int unsigned j;
        bit          waiting;
        bit          bad;
        step_units.delete();
        waiting = 1'b0;
        if (win_len < 4)
        begin
            win_q[win_len] = b.in_byte;
            win_len++;
        end
        while (win_len != 0 && step_units.size() < MAX_PER_BYTE && !waiting)
        begin
            lead = win_q[0];
            if (lead[7] == 1'b0)
            begin
                extra = 0;
                cp    = lead;
            end
            else if (lead[7:5] == 3'b110)
            begin
                extra = 1;
                cp    = lead[4:0];
            end
            else if (lead[7:4] == 4'b1110)
            begin
                extra = 2;
                cp    = lead[3:0];
            end
            else if (lead[7:3] == 5'b11110)
            begin
                extra = 3;
                cp    = lead[2:0];
            end
            else
            begin
                extra = 0;
                cp    = u8u16_pkg::REPL_CHAR;
            end
            if (win_len < extra + 1)
            begin
                waiting = !b.end_of_text;
                cp      = u8u16_pkg::REPL_CHAR;
                used    = 1;
            end
            else
            begin
                used = extra + 1;
                bad  = 1'b0;
                for (j = 1; j <= extra && !bad; j++)
                begin
                    if (win_q[j][7:6] != 2'b10)
                    begin
                        bad  = 1'b1;
                        cp   = u8u16_pkg::REPL_CHAR;
                        used = j;
                    end
                    else
                        cp = (cp << 6) | win_q[j][5:0];
                end
            end
            if (!waiting)
            begin
                for (j = 0; j + used < 4; j++)
                    win_q[j] = win_q[j + used];
                win_len -= used;
                push_code(cp);
            end
        end
        if (b.end_of_text)
        begin
            win_len = 0;
            if (step_units.size() != 0)
                step_units[step_units.size() - 1].last_unit = 1'b1;
        end
        foreach (step_units[i])
            expected_units.push_back(step_units[i]);
    endtask

    task automatic note_mismatch(input string what, input int exp_v, input int got_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, exp_v, got_v);
    endtask

    // drive input beats; hold payload until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                transcode_byte(in_data);
                bytes_sent <= bytes_sent + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_data  <= pending_bytes.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver backpressure, including the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            units_checked <= units_checked + 1;
            if (expected_units.size() == 0)
                note_mismatch("unexpected code_unit", 0, out_data.code_unit);
            else
            begin
                if (out_data.code_unit !== expected_units[0].code_unit)
                    note_mismatch("code_unit", expected_units[0].code_unit, out_data.code_unit);
                if (out_data.last_unit !== expected_units[0].last_unit)
                    note_mismatch("last_unit", expected_units[0].last_unit, out_data.last_unit);
                void'(expected_units.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d units outstanding",
                     cycle_cnt, expected_units.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_text(input logic [7:0] txt[$]);
        u8u16_pkg::in_beat_t b;
        foreach (txt[i])
        begin
            b.in_byte     = txt[i];
            b.end_of_text = (i == txt.size() - 1);
            pending_bytes.push_back(b);
        end
        texts_built++;
    endtask

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic logic [7:0] lead_byte(input int n);
        case (n)
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            default: return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    task automatic add_text(output int n_bytes);
        logic [7:0] txt[$];
        logic [7:0] brk;
        int         kind;
        int         n;
        int         n_chars;
        n_chars = $urandom_range(1, 8);
        repeat (n_chars)
        begin
            kind = $urandom_range(0, 99);
            n    = $urandom_range(2, 4);
            if (kind < 25)
                txt.push_back({1'b0, 7'($urandom)});
            else if (kind < 72)
            begin
                n = (kind < 45) ? 2 : (kind < 60) ? 3 : 4;
                txt.push_back(lead_byte(n));
                repeat (n - 1) txt.push_back(cont_byte());
            end
            else if (kind < 82)
                txt.push_back(8'($urandom));
            else if (kind < 92)
            begin
                txt.push_back(lead_byte(n));
                repeat ($urandom_range(0, n - 2)) txt.push_back(cont_byte());
            end
            else
            begin
                txt.push_back(lead_byte(n));
                repeat ($urandom_range(0, n - 2)) txt.push_back(cont_byte());
                brk = 8'($urandom);
                if (brk[7:6] == 2'b10)
                    brk[7] = 1'b0;
                txt.push_back(brk);
            end
        end
        n_bytes = txt.size();
        push_text(txt);
    endtask

    task automatic add_random(input int target);
        int added;
        int n_bytes;
        added = 0;
        while (added < target)
        begin
            add_text(n_bytes);
            added += n_bytes;
        end
    endtask

    task automatic drain();
        while (pending_bytes.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_units.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] txt[$];
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ASCII extremes, 2/3/4-byte forms, above-range, invalid leads, broken tail
        txt = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80,
                8'h80, 8'hFF, 8'hF8, 8'hE2, 8'h41};
        push_text(txt);
        txt = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hE2, 8'h82};
        push_text(txt);
        drain();

        send_idle_pct = 20;
        recv_idle_pct = 50;
        add_random(115);
        hold_req = 1'b1;
        while (hold_left == 0)
            @(negedge clk);
        hold_req = 1'b0;
        drain();

        send_idle_pct = 50;
        recv_idle_pct = 20;
        add_random(115);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(105);
        drain();

        repeat (20) @(posedge clk);
        #1;
        $display("Sent %0d bytes in %0d texts; checked %0d code units, %0d mismatches.",
                 bytes_sent, texts_built, units_checked, mismatches);
        $display("Covered all sequence lengths, invalid leads, broken and cut-short sequences,");
        $display("and a %0d-cycle receiver hold-off.", HOLD_CYCLES);
        if (mismatches == 0 && expected_units.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
